>>> rtl/core/motor_command_interpreter_unit_macros.svh
// Assertion macros for the motor command interpreter unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MOTOR_COMMAND_INTERPRETER_UNIT_MACROS_SVH
`define MOTOR_COMMAND_INTERPRETER_UNIT_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset.
`define MCI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mci assertion failed");
// Checked at every edge, reset included.
`define MCI_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("mci reset assertion failed");
`else
`define MCI_ASSERT(name, prop)
`define MCI_ASSERT_RST(name, prop)
`endif
`endif

>>> rtl/core/mci_pkg.sv
// Package for the motor command interpreter: message codes, command bytes,
// drive patterns, reset values and the result structure. No dependencies.
`default_nettype none

package mci_pkg;

  // Number of bytes read after a duty prompt.
  localparam int unsigned ENTRY_DIGITS = 3;
  localparam logic [1:0]  ENTRY_START  = 2'(ENTRY_DIGITS);

  typedef enum logic [3:0] {
    MSG_NONE    = 4'd0,
    MSG_OK      = 4'd1,
    MSG_ON      = 4'd2,
    MSG_OFF     = 4'd3,
    MSG_ACW     = 4'd4,
    MSG_CW      = 4'd5,
    MSG_ERROR   = 4'd6,
    MSG_HELP    = 4'd7,
    MSG_PROMPT  = 4'd8,
    MSG_PRESET1 = 4'd9,
    MSG_PRESET2 = 4'd10,
    MSG_PRESET3 = 4'd11,
    MSG_PRESET4 = 4'd12,
    MSG_PRESET5 = 4'd13
  } msg_e;

  // Command bytes (ASCII).
  localparam logic [7:0] CMD_ON      = 8'h41;  // A
  localparam logic [7:0] CMD_OFF     = 8'h42;  // B
  localparam logic [7:0] CMD_ACW     = 8'h43;  // C
  localparam logic [7:0] CMD_CW      = 8'h44;  // D
  localparam logic [7:0] CMD_CHECK   = 8'h46;  // F
  localparam logic [7:0] CMD_HELP    = 8'h48;  // H
  localparam logic [7:0] CMD_PROMPT  = 8'h50;  // P
  localparam logic [7:0] CMD_PRESET1 = 8'h31;
  localparam logic [7:0] CMD_PRESET2 = 8'h32;
  localparam logic [7:0] CMD_PRESET3 = 8'h33;
  localparam logic [7:0] CMD_PRESET4 = 8'h34;
  localparam logic [7:0] CMD_PRESET5 = 8'h35;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Drive and lamp patterns.
  localparam logic [5:0] PAT_CW  = 6'd37;
  localparam logic [5:0] PAT_CCW = 6'd22;
  localparam logic [5:0] PAT_OFF = 6'd8;

  localparam logic [7:0] DUTY_RESET = 8'd255;
  localparam logic [9:0] DUTY_LIMIT = 10'd256;

  typedef struct packed {
    msg_e       message;
    logic [5:0] pattern;
    logic [7:0] duty;
  } result_t;

  function automatic logic [7:0] preset_duty(input logic [2:0] idx);
    logic [7:0] d;
    case (idx)
      3'd0:    d = 8'd150;
      3'd1:    d = 8'd175;
      3'd2:    d = 8'd200;
      3'd3:    d = 8'd225;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mci_in_reg.sv
// Input register of the motor command interpreter.
// Holds one received byte until the core consumes it. Uses no package.
`default_nettype none

module mci_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       in_ready_o,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

>>> rtl/core/mci_core.sv
// Command interpreter core: motor, direction, duty and entry state, and the
// per-byte decision that forms one result. Depends on mci_pkg.
`default_nettype none

module mci_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output mci_pkg::result_t result_o
);

  logic       motor_on_q, motor_on_d;
  logic       clockwise_q, clockwise_d;
  logic [7:0] duty_q, duty_d;
  logic [5:0] pattern_q, pattern_d;
  logic [1:0] count_q, count_d;
  logic [9:0] value_q, value_d;
  logic       stopped_q, stopped_d;
  mci_pkg::msg_e msg;

  logic       is_digit;
  logic [9:0] value_acc;
  logic [2:0] preset_idx;

  assign is_digit   = (byte_i inside {[mci_pkg::CHAR_ZERO : mci_pkg::CHAR_NINE]});
  // value * 10 + digit, wrapping at ten bits.
  assign value_acc  = {value_q[6:0], 3'b000} + {value_q[8:0], 1'b0}
                    + {6'd0, 4'(byte_i - mci_pkg::CHAR_ZERO)};
  assign preset_idx = 3'(byte_i - mci_pkg::CMD_PRESET1);

  always_comb begin
    motor_on_d  = motor_on_q;
    clockwise_d = clockwise_q;
    duty_d      = duty_q;
    pattern_d   = pattern_q;
    count_d     = count_q;
    value_d     = value_q;
    stopped_d   = stopped_q;
    msg         = mci_pkg::MSG_NONE;

    if (count_q != 2'd0) begin
      // Any byte during an entry is an entry byte, command letters too.
      if (!stopped_q && is_digit) begin
        value_d = value_acc;
      end else begin
        stopped_d = 1'b1;
      end
      count_d = count_q - 2'd1;
      if (count_d == 2'd0 && value_d < mci_pkg::DUTY_LIMIT) begin
        duty_d = value_d[7:0];
      end
    end else begin
      case (byte_i)
        mci_pkg::CMD_CHECK: begin
          msg = mci_pkg::MSG_OK;
        end
        mci_pkg::CMD_ON: begin
          motor_on_d = 1'b1;
          pattern_d  = clockwise_q ? mci_pkg::PAT_CW : mci_pkg::PAT_CCW;
          msg        = mci_pkg::MSG_ON;
        end
        mci_pkg::CMD_OFF: begin
          motor_on_d = 1'b0;
          pattern_d  = mci_pkg::PAT_OFF;
          msg        = mci_pkg::MSG_OFF;
        end
        mci_pkg::CMD_ACW: begin
          if (motor_on_q) begin
            clockwise_d = 1'b0;
            pattern_d   = mci_pkg::PAT_CCW;
            msg         = mci_pkg::MSG_ACW;
          end else begin
            msg = mci_pkg::MSG_ERROR;
          end
        end
        mci_pkg::CMD_CW: begin
          if (motor_on_q) begin
            clockwise_d = 1'b1;
            pattern_d   = mci_pkg::PAT_CW;
            msg         = mci_pkg::MSG_CW;
          end else begin
            msg = mci_pkg::MSG_ERROR;
          end
        end
        mci_pkg::CMD_HELP: begin
          msg = mci_pkg::MSG_HELP;
        end
        mci_pkg::CMD_PROMPT: begin
          count_d   = mci_pkg::ENTRY_START;
          value_d   = 10'd0;
          stopped_d = 1'b0;
          msg       = mci_pkg::MSG_PROMPT;
        end
        mci_pkg::CMD_PRESET1, mci_pkg::CMD_PRESET2, mci_pkg::CMD_PRESET3,
        mci_pkg::CMD_PRESET4, mci_pkg::CMD_PRESET5: begin
          duty_d = mci_pkg::preset_duty(preset_idx);
          msg    = mci_pkg::msg_e'(4'(mci_pkg::MSG_PRESET1) + {1'b0, preset_idx});
        end
        default: begin
          msg = mci_pkg::MSG_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_on_q  <= 1'b0;
      clockwise_q <= 1'b1;
      duty_q      <= mci_pkg::DUTY_RESET;
      pattern_q   <= mci_pkg::PAT_OFF;
      count_q     <= 2'd0;
      value_q     <= 10'd0;
      stopped_q   <= 1'b0;
    end else if (fire_i) begin
      motor_on_q  <= motor_on_d;
      clockwise_q <= clockwise_d;
      duty_q      <= duty_d;
      pattern_q   <= pattern_d;
      count_q     <= count_d;
      value_q     <= value_d;
      stopped_q   <= stopped_d;
    end
  end

  assign result_o.message = msg;
  assign result_o.pattern = pattern_d;
  assign result_o.duty    = duty_d;

endmodule

`default_nettype wire

>>> rtl/core/mci_out_reg.sv
// Result register of the motor command interpreter.
// Holds one result until the consumer takes it. Depends on mci_pkg.
`default_nettype none

module mci_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mci_pkg::result_t result_i,
  input  logic             out_ready_i,
  output logic             advance_o,
  output logic             out_valid_o,
  output mci_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  mci_pkg::result_t result_q;

  // The register can take a new result when empty or being drained.
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

>>> rtl/core/motor_command_interpreter_unit.sv
// Channel  | Direction | Handshake                | Payload
// request  | in        | in_valid_i / in_ready_o  | rx_byte_i[7:0]
// result   | out       | out_valid_o / out_ready_i| message_o[3:0], port_pattern_o[5:0], duty_o[7:0]
//
// One byte per cycle sustained while results are taken; an accepted request passes
// through the input register, then the result register, before its result is presented.
// The interpreter state updates as a byte moves into the result register.
// A stalled result holds both registers; in_ready_o drops only then.
// Reset (rst_ni low) empties both registers and restores the motor state.
// Top level; depends on mci_pkg, mci_in_reg, mci_core, mci_out_reg.
`default_nettype none
`include "motor_command_interpreter_unit_macros.svh"

module motor_command_interpreter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] message_o,
  output logic [5:0] port_pattern_o,
  output logic [7:0] duty_o
);

  logic             advance;
  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             fire;
  mci_pkg::result_t core_result;
  mci_pkg::result_t out_result;

  mci_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .in_ready_o (in_ready_o),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  assign fire = stage_valid && advance;

  mci_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (stage_byte),
    .result_o (core_result)
  );

  mci_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (core_result),
    .out_ready_i (out_ready_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign message_o      = out_result.message;
  assign port_pattern_o = out_result.pattern;
  assign duty_o         = out_result.duty;

  `MCI_ASSERT(a_pattern_legal, out_valid_o |-> (port_pattern_o == mci_pkg::PAT_CW || port_pattern_o == mci_pkg::PAT_CCW || port_pattern_o == mci_pkg::PAT_OFF))
  `MCI_ASSERT(a_preset5_duty, (out_valid_o && message_o == mci_pkg::MSG_PRESET5) |-> (duty_o == mci_pkg::DUTY_RESET))
  `MCI_ASSERT(a_stall_only_when_held, !in_ready_o |-> (out_valid_o && !out_ready_i))
  `MCI_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for motor_command_interpreter_unit: an in-line predictor of
// the motor, direction, duty and duty-entry state is compared against every result.
// Depends on mci_pkg and the motor_command_interpreter_unit RTL.
`timescale 1ns / 100ps

module tb_top;
  import mci_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] message_o;
  logic [5:0] port_pattern_o;
  logic [7:0] duty_o;

  // Predicted interpreter state.
  logic       motor_is_on;
  logic       turn_cw;
  logic [7:0] duty_now;
  logic [5:0] pattern_now;
  logic [1:0] digits_left;
  logic [9:0] entry_acc;
  logic       entry_halted;

  result_t predicted_results[$];
  int      send_idle_pct;
  int      recv_idle_pct;
  int      error_count;
  int      result_count;
  int      cycle_count;

  motor_command_interpreter_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .message_o      (message_o),
    .port_pattern_o (port_pattern_o),
    .duty_o         (duty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_motor_state();
    motor_is_on  = 1'b0;
    turn_cw      = 1'b1;
    duty_now     = DUTY_RESET;
    pattern_now  = PAT_OFF;
    digits_left  = 2'd0;
    entry_acc    = 10'd0;
    entry_halted = 1'b0;
  endfunction

  // Applies one byte to the predicted state and returns the result it gives.
  function automatic result_t interpret_byte(input logic [7:0] b);
    result_t r;
    msg_e    msg;
    msg = MSG_NONE;
    if (digits_left != 2'd0) begin
      // While an entry is pending every byte is an entry byte, commands included.
      if (!entry_halted && b >= CHAR_ZERO && b <= CHAR_NINE) begin
        entry_acc = entry_acc * 10'd10 + 10'(b - CHAR_ZERO);
      end else begin
        entry_halted = 1'b1;
      end
      digits_left = digits_left - 2'd1;
      if (digits_left == 2'd0 && entry_acc < DUTY_LIMIT) begin
        duty_now = entry_acc[7:0];
      end
    end else begin
      case (b)
        CMD_CHECK: msg = MSG_OK;
        CMD_HELP:  msg = MSG_HELP;
        CMD_ON: begin
          motor_is_on = 1'b1;
          pattern_now = turn_cw ? PAT_CW : PAT_CCW;
          msg = MSG_ON;
        end
        CMD_OFF: begin
          motor_is_on = 1'b0;
          pattern_now = PAT_OFF;
          msg = MSG_OFF;
        end
        CMD_ACW: begin
          if (motor_is_on) begin
            turn_cw = 1'b0;
            pattern_now = PAT_CCW;
            msg = MSG_ACW;
          end else begin
            msg = MSG_ERROR;
          end
        end
        CMD_CW: begin
          if (motor_is_on) begin
            turn_cw = 1'b1;
            pattern_now = PAT_CW;
            msg = MSG_CW;
          end else begin
            msg = MSG_ERROR;
          end
        end
        CMD_PROMPT: begin
          digits_left  = ENTRY_START;
          entry_acc    = 10'd0;
          entry_halted = 1'b0;
          msg = MSG_PROMPT;
        end
        CMD_PRESET1: begin
          duty_now = 8'd150;
          msg = MSG_PRESET1;
        end
        CMD_PRESET2: begin
          duty_now = 8'd175;
          msg = MSG_PRESET2;
        end
        CMD_PRESET3: begin
          duty_now = 8'd200;
          msg = MSG_PRESET3;
        end
        CMD_PRESET4: begin
          duty_now = 8'd225;
          msg = MSG_PRESET4;
        end
        CMD_PRESET5: begin
          duty_now = 8'd255;
          msg = MSG_PRESET5;
        end
        default: msg = MSG_NONE;
      endcase
    end
    r.message = msg;
    r.pattern = pattern_now;
    r.duty    = duty_now;
    return r;
  endfunction

  function automatic void note_failure(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] ERROR: %s", $realtime, what);
    end
  endfunction

  // Sends one request; the sender may idle first, and valid stays up until accepted.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_results.push_back(interpret_byte(b));
  endtask

  // Holds off new requests until every predicted result has been seen.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_entry(input logic [7:0] c0, input logic [7:0] c1,
                            input logic [7:0] c2);
    send_byte(CMD_PROMPT);
    send_byte(c0);
    send_byte(c1);
    send_byte(c2);
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    return CHAR_ZERO + 8'(d);
  endfunction

  task automatic test_motor_commands();
    // Direction commands while off must give an error and leave the direction alone.
    send_byte(CMD_CHECK);
    send_byte(CMD_HELP);
    send_byte(CMD_ACW);
    send_byte(CMD_ON);
    send_byte(CMD_ACW);
    send_byte(CMD_OFF);
    send_byte(CMD_CW);
    send_byte(CMD_ON);
    send_byte(CMD_CW);
    send_byte(CMD_OFF);
  endtask

  task automatic test_unknown_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_presets();
    send_byte(CMD_PRESET5);
    send_byte(CMD_PRESET4);
    send_byte(CMD_PRESET2);
    send_byte(CMD_PRESET1);
    send_byte(CMD_PRESET3);
  endtask

  task automatic test_duty_entry();
    // 256 is not below the limit, so the duty is kept.
    send_entry(digit_char(2), digit_char(5), digit_char(6));
    // A command letter inside an entry is only a non-digit: the value ends as 0.
    send_entry(CMD_ON, digit_char(9), digit_char(9));
  endtask

  task automatic test_random_traffic(input int n_items);
    int          sent;
    int unsigned kind;
    int unsigned val;
    logic [7:0]  cmd_list [12];
    sent = 0;
    cmd_list = '{CMD_ON, CMD_OFF, CMD_ACW, CMD_CW, CMD_CHECK, CMD_HELP,
                 CMD_PRESET1, CMD_PRESET2, CMD_PRESET3, CMD_PRESET4, CMD_PRESET5,
                 CMD_ON};
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // Well-formed entry, often near the duty limit.
        if ($urandom_range(0, 4) == 0) begin
          val = $urandom_range(250, 260);
        end else if ($urandom_range(0, 1) == 0) begin
          val = $urandom_range(0, 299);
        end else begin
          val = $urandom_range(0, 999);
        end
        send_entry(digit_char(val / 100), digit_char((val / 10) % 10), digit_char(val % 10));
        sent += 4;
      end else if (kind < 50) begin
        // Entry with stray bytes mixed into the digits.
        send_byte(CMD_PROMPT);
        repeat (3) begin
          if ($urandom_range(0, 2) == 0) begin
            send_byte(8'($urandom_range(0, 255)));
          end else begin
            send_byte(digit_char($urandom_range(0, 9)));
          end
        end
        sent += 4;
      end else if (kind < 85) begin
        send_byte(cmd_list[$urandom_range(0, 11)]);
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (predicted_results.size() == 0) begin
        note_failure($sformatf("result %0d with no request pending: msg=%0d pat=%0d duty=%0d",
                               result_count, message_o, port_pattern_o, duty_o));
      end else begin
        want = predicted_results.pop_front();
        if (message_o !== want.message || port_pattern_o !== want.pattern ||
            duty_o !== want.duty) begin
          note_failure($sformatf({"result %0d: expected msg=%0d pat=%0d duty=%0d, ",
                                  "got msg=%0d pat=%0d duty=%0d"},
                                 result_count, want.message, want.pattern, want.duty,
                                 message_o, port_pattern_o, duty_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    result_count  = 0;
    cycle_count   = 0;
    send_idle_pct = 14;
    recv_idle_pct = 72;
    clear_motor_state();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_motor_commands();
    test_unknown_bytes();
    test_presets();
    test_duty_entry();
    wait_drained();

    test_random_traffic(400);
    wait_drained();
    send_idle_pct = 72;
    recv_idle_pct = 14;
    test_random_traffic(400);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(400);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", predicted_results.size()));
    end
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mci_pkg.sv
rtl/core/mci_in_reg.sv
rtl/core/mci_core.sv
rtl/core/mci_out_reg.sv
rtl/core/motor_command_interpreter_unit.sv
tb/tb_top.sv
